@@ rtl/rrts_pkg.sv @@
package rrts_pkg;

  localparam int SLOTS_DEF    = 16;

  localparam int FUNC_W       = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int TID_W        = 32;
  localparam int STATUS_W     = 2;

  localparam int IN_FIELDS_W  = FUNC_W + SLOT_FIELD_W + 1;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + SLOT_FIELD_W + TID_W + 1 + SLOT_FIELD_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_YIELD   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic scan_inc;
    logic create_commit;
    logic no_slot;
    logic walk_start;
    logic walk_adv;
    logic unlink;
    logic rd_head;
    logic yield_empty;
    logic yield_commit;
    logic out_load;
  } rrts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_create;
    logic in_destroy;
    logic in_yield;
    logic scan_dead;
    logic scan_last;
    logic dest_live;
    logic walk_hit;
    logic queue_empty;
    logic out_free;
  } rrts_sts_t;

endpackage

@@ rtl/rrts_ram.sv @@
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rrts_ctrl.sv @@
module rrts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rrts_pkg::rrts_sts_t sts,
  output rrts_pkg::rrts_cmd_t cmd
);

  import rrts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_DEST     = 8'b0000_0100,
    S_WALK_RD  = 8'b0000_1000,
    S_WALK_CHK = 8'b0001_0000,
    S_YIELD    = 8'b0010_0000,
    S_YIELD_RD = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } rrts_state_t;

  rrts_state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          if (sts.in_create) begin
            state_nxt = S_SCAN;
          end else if (sts.in_destroy) begin
            state_nxt = S_DEST;
          end else if (sts.in_yield) begin
            state_nxt = S_YIELD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_dead) begin
          cmd.create_commit = 1'b1;
          state_nxt         = S_DONE;
        end else if (sts.scan_last) begin
          cmd.no_slot = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_DEST: begin
        if (sts.dest_live) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (sts.walk_hit) begin
          cmd.unlink = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_WALK_RD;
        end
      end
      S_YIELD: begin
        if (sts.queue_empty) begin
          cmd.yield_empty = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_YIELD_RD;
        end
      end
      S_YIELD_RD: begin
        cmd.yield_commit = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/rrts_dp.sv @@
module rrts_dp #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rrts_pkg::IN_DATA_W-1:0] in_tdata,
  output logic [rrts_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  rrts_pkg::rrts_cmd_t            cmd,
  output rrts_pkg::rrts_sts_t            sts
);

  import rrts_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int SWX   = (SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W;
  localparam int CMP_W = SWX + 1;

  // input fields
  logic [FUNC_W-1:0]       in_func;
  logic [SLOT_FIELD_W-1:0] in_dslot;
  logic                    in_frame;

  assign in_func  = in_tdata[FUNC_W-1:0];
  assign in_dslot = in_tdata[FUNC_W +: SLOT_FIELD_W];
  assign in_frame = in_tdata[FUNC_W + SLOT_FIELD_W];

  // item and walk registers
  logic [SLOT_FIELD_W-1:0] dslot_r, dslot_nxt;
  logic                    frame_r, frame_nxt;
  logic [SW-1:0]           scan_r, scan_nxt;
  logic [SW-1:0]           cur_r, cur_nxt;
  logic [SW-1:0]           prev_r, prev_nxt;
  logic                    have_prev_r, have_prev_nxt;

  // scheduler state
  logic [SLOTS-1:0]        alive_r, alive_nxt;
  logic [SW-1:0]           head_r, head_nxt;
  logic [SW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [TID_W-1:0]        next_id_r, next_id_nxt;
  logic [SW-1:0]           run_slot_r, run_slot_nxt;
  logic                    run_valid_r, run_valid_nxt;

  // result being built, and the output register
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [SLOT_FIELD_W-1:0] res_slot_r, res_slot_nxt;
  logic [TID_W-1:0]        res_tid_r, res_tid_nxt;
  logic                    res_sw_r, res_sw_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // memories
  logic                    link_we;
  logic [SW-1:0]           link_waddr;
  logic [SW-1:0]           link_wdata;
  logic [SW-1:0]           link_raddr;
  logic [SW-1:0]           link_rdata;
  logic                    tid_we;
  logic [TID_W-1:0]        tid_rdata;

  // slot index <-> 4-bit field
  logic [SWX-1:0]          dslot_ext;
  logic [SWX-1:0]          scan_ext;
  logic [SWX-1:0]          head_ext;
  logic [SWX-1:0]          run_ext;
  logic [SW-1:0]           dslot_idx;
  logic                    dslot_in_range;
  logic                    yield_switch;

  assign dslot_ext      = SWX'(dslot_r);
  assign scan_ext       = SWX'(scan_r);
  assign head_ext       = SWX'(head_r);
  assign run_ext        = SWX'(run_slot_r);
  assign dslot_idx      = dslot_ext[SW-1:0];
  assign dslot_in_range = CMP_W'(dslot_r) < CMP_W'(SLOTS);
  assign yield_switch   = !run_valid_r || (run_slot_r != head_r);

  assign link_raddr = cmd.rd_head ? head_r : cur_r;

  rrts_ram #(
    .WIDTH(SW),
    .DEPTH(SLOTS)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  rrts_ram #(
    .WIDTH(TID_W),
    .DEPTH(SLOTS)
  ) u_tid_ram (
    .clk  (clk),
    .we   (tid_we),
    .waddr(scan_r),
    .wdata(next_id_r),
    .raddr(head_r),
    .rdata(tid_rdata)
  );

  always_comb begin
    sts.in_create   = (in_func == FUNC_CREATE);
    sts.in_destroy  = (in_func == FUNC_DESTROY);
    sts.in_yield    = (in_func == FUNC_YIELD);
    sts.scan_dead   = !alive_r[scan_r];
    sts.scan_last   = (scan_r == SW'(SLOTS - 1));
    sts.dest_live   = dslot_in_range && alive_r[dslot_idx];
    sts.walk_hit    = (cur_r == dslot_idx);
    sts.queue_empty = (count_r == '0);
    sts.out_free    = !out_valid_r || out_tready;
  end

  always_comb begin
    dslot_nxt      = dslot_r;
    frame_nxt      = frame_r;
    scan_nxt       = scan_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    alive_nxt      = alive_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    next_id_nxt    = next_id_r;
    run_slot_nxt   = run_slot_r;
    run_valid_nxt  = run_valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_tid_nxt    = res_tid_r;
    res_sw_nxt     = res_sw_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    link_we        = 1'b0;
    link_waddr     = scan_r;
    link_wdata     = head_r;
    tid_we         = 1'b0;

    if (cmd.load_item) begin
      dslot_nxt      = in_dslot;
      frame_nxt      = in_frame;
      scan_nxt       = '0;
      res_status_nxt = STATUS_OK;
      res_slot_nxt   = (in_func == FUNC_DESTROY) ? in_dslot : '0;
      res_tid_nxt    = '0;
      res_sw_nxt     = 1'b0;
    end

    if (cmd.scan_inc) begin
      scan_nxt = scan_r + 1'b1;
    end

    if (cmd.create_commit) begin
      if (frame_r) begin
        // new thread goes in at the head of the queue
        tid_we            = 1'b1;
        link_we           = 1'b1;
        link_waddr        = scan_r;
        link_wdata        = head_r;
        alive_nxt[scan_r] = 1'b1;
        head_nxt          = scan_r;
        if (count_r == '0) begin
          tail_nxt = scan_r;
        end
        count_nxt    = count_r + 1'b1;
        next_id_nxt  = next_id_r + 1'b1;
        res_slot_nxt = scan_ext[SLOT_FIELD_W-1:0];
        res_tid_nxt  = next_id_r;
      end else begin
        res_status_nxt = STATUS_NO_FRAME;
      end
    end

    if (cmd.no_slot) begin
      res_status_nxt = STATUS_NO_SLOT;
    end

    if (cmd.walk_start) begin
      cur_nxt       = head_r;
      have_prev_nxt = 1'b0;
    end

    if (cmd.walk_adv) begin
      prev_nxt      = cur_r;
      have_prev_nxt = 1'b1;
      cur_nxt       = link_rdata;
    end

    if (cmd.unlink) begin
      // link_rdata holds the successor of the slot being removed
      if (have_prev_r) begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = link_rdata;
      end else begin
        head_nxt = link_rdata;
      end
      if (tail_r == cur_r) begin
        tail_nxt = have_prev_r ? prev_r : '0;
      end
      count_nxt = count_r - 1'b1;
      if (count_r == CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
      alive_nxt[cur_r] = 1'b0;
      if (run_valid_r && (run_slot_r == cur_r)) begin
        run_valid_nxt = 1'b0;
        run_slot_nxt  = '0;
      end
    end

    if (cmd.yield_empty) begin
      res_status_nxt = STATUS_EMPTY;
    end

    if (cmd.yield_commit) begin
      // rotate head to tail; a lone thread stays where it is
      if (count_r > CW'(1)) begin
        head_nxt   = link_rdata;
        link_we    = 1'b1;
        link_waddr = tail_r;
        link_wdata = head_r;
        tail_nxt   = head_r;
      end
      if (yield_switch) begin
        run_slot_nxt  = head_r;
        run_valid_nxt = 1'b1;
      end
      res_slot_nxt = head_ext[SLOT_FIELD_W-1:0];
      res_tid_nxt  = tid_rdata;
      res_sw_nxt   = yield_switch;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{OUT_PAD_W{1'b0}}, run_valid_r, run_ext[SLOT_FIELD_W-1:0],
                       res_sw_r, res_tid_r, res_slot_r, res_status_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      next_id_r   <= TID_W'(1);
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      alive_r     <= alive_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      run_slot_r  <= run_slot_nxt;
      run_valid_r <= run_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dslot_r      <= dslot_nxt;
    frame_r      <= frame_nxt;
    scan_r       <= scan_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    have_prev_r  <= have_prev_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_tid_r    <= res_tid_nxt;
    res_sw_r     <= res_sw_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/round_robin_thread_scheduler_unit.sv @@
// Channel  Ports                       Fields, lowest bit first
// -------  --------------------------  ---------------------------------------------
// in       in_tvalid/in_tready/in_tdata    func[1:0] destroy_slot[5:2] frame_ok[6]
// out      out_tvalid/out_tready/out_tdata status[1:0] thread_slot[5:2]
//                                          thread_id[37:6] switched[38]
//                                          current_slot[42:39] current_valid[43]
//
// One operation at a time, each run through to its result in the output register:
// create by the one-slot-a-cycle search for the lowest dead slot;
// destroy of a live thread by a link walk from the queue head to its place;
// yield by a read of the queue head, skipped on an empty queue; other operations need no search.
// The next transfer is taken the cycle after the result loads.
// rst_n is synchronous: all slots dead, queue empty, next identifier one.
// A stalled output holds its result; a new item is accepted meanwhile but its result waits.
module round_robin_thread_scheduler_unit #(
  parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // func, destroy_slot, frame_ok, zero pad
  input  logic [rrts_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, thread_slot, thread_id, switched, current_slot, current_valid, zero pad
  output logic [rrts_pkg::OUT_DATA_W-1:0] out_tdata
);

  import rrts_pkg::*;

  rrts_cmd_t cmd;
  rrts_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
